// ----- rtl/core/cld_pkg.sv -----
// Shared types, constants and helpers of the content-length message deframer.
`default_nettype none

package cld_pkg;

    // Default width of the length counters
    localparam int LENGTH_BITS_DEF = 32;

    // Result event codes
    localparam logic [2:0] EV_BODY      = 3'd0;
    localparam logic [2:0] EV_EMPTY     = 3'd1;
    localparam logic [2:0] EV_NAME_LF   = 3'd2;
    localparam logic [2:0] EV_BAD_LEN   = 3'd3;
    localparam logic [2:0] EV_NUL       = 3'd4;
    localparam logic [2:0] EV_CR_NO_LF  = 3'd5;
    localparam logic [2:0] EV_VALUE_LF  = 3'd6;

    // Characters of interest
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NUL   = 8'h00;

    // Length of the header name matched against
    localparam logic [3:0] KEY_LEN = 4'd14;

    // One result beat from the parser
    typedef struct packed {
        logic       valid;
        logic [7:0] body_byte;
        logic       last;
        logic [2:0] ev;
    } t_res;

    // Upper-case header name CONTENT-LENGTH, one letter per index
    function automatic logic [7:0] key_char(input logic [3:0] idx);
        logic [7:0] c;
        unique case (idx)
            4'd0:    c = 8'h43; // C
            4'd1:    c = 8'h4f; // O
            4'd2:    c = 8'h4e; // N
            4'd3:    c = 8'h54; // T
            4'd4:    c = 8'h45; // E
            4'd5:    c = 8'h4e; // N
            4'd6:    c = 8'h54; // T
            4'd7:    c = 8'h2d; // -
            4'd8:    c = 8'h4c; // L
            4'd9:    c = 8'h45; // E
            4'd10:   c = 8'h4e; // N
            4'd11:   c = 8'h47; // G
            4'd12:   c = 8'h54; // T
            4'd13:   c = 8'h48; // H
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/cld_parser.sv -----
// Header/body parse state and the per-byte step logic of the deframer.
`default_nettype none

module cld_parser #(
    parameter int LENGTH_BITS = cld_pkg::LENGTH_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_fire,
    input  wire logic [7:0]  i_byte,
    output cld_pkg::t_res    o_res
);

    // Parse phase codes; unused codes behave as name start
    localparam logic [2:0] PH_NAME       = 3'd0;
    localparam logic [2:0] PH_NAME_CR    = 3'd1;
    localparam logic [2:0] PH_VALUE_LEAD = 3'd2;
    localparam logic [2:0] PH_VALUE      = 3'd3;
    localparam logic [2:0] PH_VALUE_CR   = 3'd4;
    localparam logic [2:0] PH_BODY       = 3'd5;

    // Digit state codes
    localparam logic [1:0] DS_NONE    = 2'd0;
    localparam logic [1:0] DS_RUN     = 2'd1;
    localparam logic [1:0] DS_ENDED   = 2'd2;
    localparam logic [1:0] DS_INVALID = 2'd3;

    logic [2:0]             r_phase, n_phase;
    logic [3:0]             r_idx, n_idx;
    logic                   r_mis, n_mis;
    logic [3:0]             r_nlen, n_nlen;
    logic                   r_cur_len, n_cur_len;
    logic                   r_seen, n_seen;
    logic [LENGTH_BITS-1:0] r_acc, n_acc;
    logic [1:0]             r_ds, n_ds;
    logic [LENGTH_BITS-1:0] r_rem, n_rem;

    logic [7:0]             up;
    logic                   is_digit;
    logic                   is_blank;
    logic [LENGTH_BITS+3:0] prod;
    logic                   ovf;
    logic [LENGTH_BITS-1:0] rem_dec;
    logic                   go_reset;
    logic                   go_name;
    cld_pkg::t_res          res;

    // Byte classification and the x10 + digit accumulate
    always_comb begin
        up       = ((i_byte >= 8'h61) && (i_byte <= 8'h7a)) ? (i_byte - 8'd32) : i_byte;
        is_digit = (i_byte >= 8'h30) && (i_byte <= 8'h39);
        is_blank = (i_byte == cld_pkg::CH_SPACE) || (i_byte == cld_pkg::CH_TAB);
        prod     = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1)
                 + {{LENGTH_BITS{1'b0}}, i_byte[3:0]};
        ovf      = |prod[LENGTH_BITS+3:LENGTH_BITS];
        rem_dec  = r_rem - {{(LENGTH_BITS-1){1'b0}}, 1'b1};
    end

    // Step logic for one byte
    always_comb begin
        n_phase   = r_phase;
        n_idx     = r_idx;
        n_mis     = r_mis;
        n_nlen    = r_nlen;
        n_cur_len = r_cur_len;
        n_seen    = r_seen;
        n_acc     = r_acc;
        n_ds      = r_ds;
        n_rem     = r_rem;
        go_reset  = 1'b0;
        go_name   = 1'b0;
        res       = '0;

        if (i_fire) begin
            if (i_byte == cld_pkg::CH_NUL) begin
                // NUL drops the message in any phase
                go_reset  = 1'b1;
                res.valid = 1'b1;
                res.ev    = cld_pkg::EV_NUL;
            end else begin
                unique case (r_phase)
                    PH_BODY: begin
                        n_rem         = rem_dec;
                        res.valid     = 1'b1;
                        res.body_byte = i_byte;
                        res.ev        = cld_pkg::EV_BODY;
                        if (rem_dec == '0) begin
                            res.last = 1'b1;
                            go_reset = 1'b1;
                        end
                    end
                    PH_NAME_CR: begin
                        if (i_byte != cld_pkg::CH_LF) begin
                            go_name   = 1'b1;
                            res.valid = 1'b1;
                            res.ev    = cld_pkg::EV_CR_NO_LF;
                        end else if ((r_nlen == 4'd0) && r_seen) begin
                            // blank line: body or empty message
                            if (r_rem == '0) begin
                                go_reset  = 1'b1;
                                res.valid = 1'b1;
                                res.last  = 1'b1;
                                res.ev    = cld_pkg::EV_EMPTY;
                            end else begin
                                n_phase = PH_BODY;
                            end
                        end else begin
                            go_reset  = 1'b1;
                            res.valid = 1'b1;
                            res.ev    = cld_pkg::EV_NAME_LF;
                        end
                    end
                    PH_VALUE_LEAD, PH_VALUE: begin
                        if (!((r_phase == PH_VALUE_LEAD) && is_blank)) begin
                            n_phase = PH_VALUE;
                            if (i_byte == cld_pkg::CH_CR) begin
                                n_phase = PH_VALUE_CR;
                            end else if (i_byte == cld_pkg::CH_LF) begin
                                go_name   = 1'b1;
                                res.valid = 1'b1;
                                res.ev    = cld_pkg::EV_VALUE_LF;
                            end else if (is_digit && (r_ds <= DS_RUN)) begin
                                if (ovf) begin
                                    n_ds = DS_INVALID;
                                end else begin
                                    n_acc = prod[LENGTH_BITS-1:0];
                                    n_ds  = DS_RUN;
                                end
                            end else if (r_ds == DS_NONE) begin
                                n_ds = DS_INVALID;
                            end else if (r_ds == DS_RUN) begin
                                n_ds = DS_ENDED;
                            end
                        end
                    end
                    PH_VALUE_CR: begin
                        if (i_byte != cld_pkg::CH_LF) begin
                            go_name   = 1'b1;
                            res.valid = 1'b1;
                            res.ev    = cld_pkg::EV_CR_NO_LF;
                        end else if (r_cur_len && !((r_ds == DS_RUN) || (r_ds == DS_ENDED))) begin
                            go_reset  = 1'b1;
                            res.valid = 1'b1;
                            res.ev    = cld_pkg::EV_BAD_LEN;
                        end else begin
                            if (r_cur_len) begin
                                n_rem  = r_acc;
                                n_seen = 1'b1;
                            end
                            go_name = 1'b1;
                        end
                    end
                    default: begin
                        // header name
                        n_phase = PH_NAME;
                        if (up == cld_pkg::CH_CR) begin
                            n_phase = PH_NAME_CR;
                        end else if (up == cld_pkg::CH_LF) begin
                            go_reset  = 1'b1;
                            res.valid = 1'b1;
                            res.ev    = cld_pkg::EV_NAME_LF;
                        end else if (up == cld_pkg::CH_COLON) begin
                            n_cur_len = !r_mis && (r_idx == cld_pkg::KEY_LEN)
                                     && (r_nlen == cld_pkg::KEY_LEN);
                            n_acc     = '0;
                            n_ds      = DS_NONE;
                            n_phase   = PH_VALUE_LEAD;
                        end else begin
                            if (!r_mis && (r_idx < cld_pkg::KEY_LEN)
                                && (up == cld_pkg::key_char(r_idx))) begin
                                n_idx = r_idx + 4'd1;
                            end else begin
                                n_mis = 1'b1;
                            end
                            if (r_nlen != 4'hf) begin
                                n_nlen = r_nlen + 4'd1;
                            end
                        end
                    end
                endcase
            end

            // Restart of the whole message or of the header parse
            if (go_reset) begin
                n_phase   = PH_NAME;
                n_idx     = '0;
                n_mis     = 1'b0;
                n_nlen    = '0;
                n_cur_len = 1'b0;
                n_seen    = 1'b0;
                n_acc     = '0;
                n_ds      = DS_NONE;
                n_rem     = '0;
            end else if (go_name) begin
                n_phase = PH_NAME;
                n_idx   = '0;
                n_mis   = 1'b0;
                n_nlen  = '0;
            end
        end
    end

    assign o_res = res;

    // Parse state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_NAME;
            r_idx     <= '0;
            r_mis     <= 1'b0;
            r_nlen    <= '0;
            r_cur_len <= 1'b0;
            r_seen    <= 1'b0;
            r_acc     <= '0;
            r_ds      <= DS_NONE;
            r_rem     <= '0;
        end else begin
            r_phase   <= n_phase;
            r_idx     <= n_idx;
            r_mis     <= n_mis;
            r_nlen    <= n_nlen;
            r_cur_len <= n_cur_len;
            r_seen    <= n_seen;
            r_acc     <= n_acc;
            r_ds      <= n_ds;
            r_rem     <= n_rem;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/content_length_message_deframer_top.sv -----
// Top level of the content-length message deframer: input register, parser, result register.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------------
//  in      | to block  | i_valid / o_stall  | i_in_byte
//  out     | from block| o_valid / i_stall  | o_body_byte, o_last_of_body, o_event_res
//
// One byte per clock sustained while i_stall is low; a byte is taken into the input
// register, passes through the parser, and its result is held in the result register,
// which drives the outputs.
// Reset is synchronous and clears the parse state at once; no start-up sweep.
// A stalled result holds in the result register; the byte behind it waits in the
// input register and o_stall rises only once both are occupied.
`default_nettype none

module content_length_message_deframer_top #(
    parameter int LENGTH_BITS = cld_pkg::LENGTH_BITS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_in_byte,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [7:0]      o_body_byte,
    output logic            o_last_of_body,
    output logic [2:0]      o_event_res
);

    logic          r_in_valid, n_in_valid;
    logic [7:0]    r_in_byte;
    logic          r_out_valid, n_out_valid;
    logic [7:0]    r_body_byte;
    logic          r_last;
    logic [2:0]    r_ev;
    logic          fire;
    logic          in_take;
    cld_pkg::t_res res;

    // Parse the held byte when the result register can take its beat
    assign fire    = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !fire;
    assign in_take = i_valid && !o_stall;

    cld_parser #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_byte  (r_in_byte),
        .o_res   (res)
    );

    always_comb begin
        n_in_valid  = in_take ? 1'b1 : (fire ? 1'b0 : r_in_valid);
        n_out_valid = fire ? res.valid : (r_out_valid && i_stall);
    end

    // Handshake state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_in_byte;
        end
        if (fire && res.valid) begin
            r_body_byte <= res.body_byte;
            r_last      <= res.last;
            r_ev        <= res.ev;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_body_byte    = r_body_byte;
    assign o_last_of_body = r_last;
    assign o_event_res    = r_ev;

endmodule

`default_nettype wire

// ----- rtl/core/cld_checker.sv -----
// Port-level checks of the deframer, bound to the top level.
`default_nettype none

module cld_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_valid,
    input wire logic       i_stall,
    input wire logic [7:0] o_body_byte,
    input wire logic       o_last_of_body,
    input wire logic [2:0] o_event_res
);

    // Only body or empty-body beats carry the last marker
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_of_body) |->
            ((o_event_res == cld_pkg::EV_BODY) || (o_event_res == cld_pkg::EV_EMPTY)))
        else $error("last marker on an error event");

    // Empty body completion always ends the message
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_event_res == cld_pkg::EV_EMPTY)) |-> o_last_of_body)
        else $error("empty body without last marker");

    // Event beats carry a zero data byte
    a_event_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_event_res != cld_pkg::EV_BODY)) |-> (o_body_byte == 8'h00))
        else $error("event beat with non-zero byte");

    // No undefined event code
    a_event_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_event_res <= cld_pkg::EV_VALUE_LF))
        else $error("undefined event code");

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=>
            (o_valid && $stable(o_body_byte) && $stable(o_last_of_body) && $stable(o_event_res)))
        else $error("stalled result beat changed");

endmodule

bind content_length_message_deframer_top cld_checker u_cld_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_body_byte    (o_body_byte),
    .o_last_of_body (o_last_of_body),
    .o_event_res    (o_event_res)
);

`default_nettype wire
